// File: hw/rtl/cell_to_node_recenter_top_macros.svh
// assertion macros for the recenter rtl
// no dependencies; included by c2n_ctrl, the module that carries assertions
`ifndef CELL_TO_NODE_RECENTER_TOP_MACROS_SVH
`define CELL_TO_NODE_RECENTER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define C2N_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("c2n assertion failed");
`define C2N_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("c2n assertion failed");
`else
`define C2N_ASSERT(name, clk, rstn, prop)
`define C2N_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// File: hw/rtl/c2n_pkg.sv
// shared types and constants for the cell to node recenter block
// no dependencies
`default_nettype none

package c2n_pkg;

    localparam int COORD_W    = 5;
    localparam int STRIDE_W   = 4;
    localparam int LAST_W     = 4;
    localparam int DIMS_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;
    localparam int SEL_W      = 3;
    // holds 31 * 15 and any clamp bound up to 255
    localparam int PROD_W     = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_DIMS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_Z   = 3'd6;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic             write;
        logic             load;
        logic             prep;
        logic [SEL_W-1:0] rd_sel;
        logic             acc;
        logic             out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [SEL_W-1:0] reads_last;
    } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/c2n_ram.sv
// generic single-port ram with registered read
// no dependencies
`default_nettype none

module c2n_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/c2n_dpath.sv
// datapath: config registers, straddle cells, field memory, accumulator
// depends on c2n_pkg and c2n_ram
`default_nettype none

module c2n_dpath #(
    parameter int AXIS_CELLS   = 16,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [c2n_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [c2n_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [c2n_pkg::COORD_W-1:0]     in_coord_x,
    input  wire logic [c2n_pkg::COORD_W-1:0]     in_coord_y,
    input  wire logic [c2n_pkg::COORD_W-1:0]     in_coord_z,
    input  wire logic signed [SAMPLE_WIDTH-1:0]  in_sample,
    input  wire c2n_pkg::dp_cmd_t                cmd,
    output c2n_pkg::dp_status_t                  status,
    output logic signed [SAMPLE_WIDTH-1:0]       node_value
);

    localparam int CW    = $clog2(AXIS_CELLS);
    localparam int DEPTH = AXIS_CELLS * AXIS_CELLS * AXIS_CELLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int ACC_W = SAMPLE_WIDTH + 3;
    localparam int PW    = c2n_pkg::PROD_W;

    logic [c2n_pkg::DIMS_W-1:0]   dims_reg;
    logic [c2n_pkg::STRIDE_W-1:0] stride_x_reg, stride_y_reg, stride_z_reg;
    logic [c2n_pkg::LAST_W-1:0]   last_x_reg, last_y_reg, last_z_reg;

    logic [c2n_pkg::COORD_W-1:0]  qx_reg, qy_reg, qz_reg;
    logic [CW-1:0]                cx0_reg, cx1_reg, cy0_reg, cy1_reg, cz0_reg, cz1_reg;
    logic signed [ACC_W-1:0]      acc_reg;
    logic signed [SAMPLE_WIDTH-1:0] node_reg;

    logic [c2n_pkg::DIMS_W-1:0]   d_eff;
    logic [CW-1:0]                wx, wy, wz, rx, ry, rz;
    logic                         w_in_range;
    logic [AW-1:0]                waddr, raddr, ram_addr;
    logic [SAMPLE_WIDTH-1:0]      rdata;
    logic signed [ACC_W-1:0]      rdata_ext, acc_shift;

    // straddling cell along one axis, clamped to [0, min(last, AXIS_CELLS - 1)]
    function automatic logic [CW-1:0] cell_at(
        input logic [c2n_pkg::COORD_W-1:0]  i,
        input logic [c2n_pkg::STRIDE_W-1:0] s,
        input logic [c2n_pkg::LAST_W-1:0]   last,
        input logic                         lower
    );
        logic [c2n_pkg::STRIDE_W-1:0] se;
        logic [PW-1:0]                p;
        logic [PW-1:0]                hi;
        se = (s == '0) ? c2n_pkg::STRIDE_W'(1) : s;
        p  = PW'(i) * PW'(se);
        if (lower) begin
            p = (i == '0) ? '0 : p - PW'(se);
        end
        if (PW'(last) > PW'(AXIS_CELLS - 1)) begin
            hi = PW'(AXIS_CELLS - 1);
        end else begin
            hi = PW'(last);
        end
        return (p > hi) ? CW'(hi) : CW'(p);
    endfunction

    function automatic logic [AW-1:0] addr_of(
        input logic [CW-1:0] x,
        input logic [CW-1:0] y,
        input logic [CW-1:0] z
    );
        return AW'(x) + AW'(AXIS_CELLS) * AW'(y)
             + AW'(AXIS_CELLS * AXIS_CELLS) * AW'(z);
    endfunction

    assign d_eff = (dims_reg == '0) ? c2n_pkg::DIMS_W'(1) : dims_reg;
    assign status.reads_last = c2n_pkg::SEL_W'((4'd1 << d_eff) - 4'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg     <= c2n_pkg::DIMS_W'(3);
            stride_x_reg <= c2n_pkg::STRIDE_W'(1);
            stride_y_reg <= c2n_pkg::STRIDE_W'(1);
            stride_z_reg <= c2n_pkg::STRIDE_W'(1);
            last_x_reg   <= c2n_pkg::LAST_W'(15);
            last_y_reg   <= c2n_pkg::LAST_W'(15);
            last_z_reg   <= c2n_pkg::LAST_W'(15);
        end else if (cfg_we) begin
            case (cfg_index)
                c2n_pkg::CFG_DIMS:     dims_reg     <= cfg_data[c2n_pkg::DIMS_W-1:0];
                c2n_pkg::CFG_STRIDE_X: stride_x_reg <= cfg_data;
                c2n_pkg::CFG_STRIDE_Y: stride_y_reg <= cfg_data;
                c2n_pkg::CFG_STRIDE_Z: stride_z_reg <= cfg_data;
                c2n_pkg::CFG_LAST_X:   last_x_reg   <= cfg_data;
                c2n_pkg::CFG_LAST_Y:   last_y_reg   <= cfg_data;
                c2n_pkg::CFG_LAST_Z:   last_z_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // write path: inactive axes land on cell 0
    always_comb begin
        logic y_ok, z_ok;
        y_ok = 1'b1;
        z_ok = 1'b1;
        wx = CW'(in_coord_x);
        wy = '0;
        wz = '0;
        if (d_eff >= 2'd2) begin
            wy   = CW'(in_coord_y);
            y_ok = (32'(in_coord_y) < AXIS_CELLS);
        end
        if (d_eff == 2'd3) begin
            wz   = CW'(in_coord_z);
            z_ok = (32'(in_coord_z) < AXIS_CELLS);
        end
        w_in_range = (32'(in_coord_x) < AXIS_CELLS) && y_ok && z_ok;
    end

    assign waddr = addr_of(wx, wy, wz);

    // corner k picks the upper cell on axis b when bit b of k is set
    assign rx    = cmd.rd_sel[0] ? cx1_reg : cx0_reg;
    assign ry    = cmd.rd_sel[1] ? cy1_reg : cy0_reg;
    assign rz    = cmd.rd_sel[2] ? cz1_reg : cz0_reg;
    assign raddr = addr_of(rx, ry, rz);

    assign ram_addr = cmd.write ? waddr : raddr;

    c2n_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (DEPTH)
    ) u_field_ram (
        .clk   (aclk),
        .we    (cmd.write && w_in_range),
        .addr  (ram_addr),
        .wdata (in_sample),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            qx_reg <= in_coord_x;
            qy_reg <= in_coord_y;
            qz_reg <= in_coord_z;
        end
        if (cmd.prep) begin
            cx0_reg <= cell_at(qx_reg, stride_x_reg, last_x_reg, 1'b1);
            cx1_reg <= cell_at(qx_reg, stride_x_reg, last_x_reg, 1'b0);
            if (d_eff >= 2'd2) begin
                cy0_reg <= cell_at(qy_reg, stride_y_reg, last_y_reg, 1'b1);
                cy1_reg <= cell_at(qy_reg, stride_y_reg, last_y_reg, 1'b0);
            end else begin
                cy0_reg <= '0;
                cy1_reg <= '0;
            end
            if (d_eff == 2'd3) begin
                cz0_reg <= cell_at(qz_reg, stride_z_reg, last_z_reg, 1'b1);
                cz1_reg <= cell_at(qz_reg, stride_z_reg, last_z_reg, 1'b0);
            end else begin
                cz0_reg <= '0;
                cz1_reg <= '0;
            end
        end
    end

    assign rdata_ext = {{3{rdata[SAMPLE_WIDTH-1]}}, rdata};
    // floor of the mean is an arithmetic shift of the full sum
    assign acc_shift = acc_reg >>> d_eff;

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            acc_reg <= '0;
        end else if (cmd.acc) begin
            acc_reg <= acc_reg + rdata_ext;
        end
        if (cmd.out_load) begin
            node_reg <= acc_shift[SAMPLE_WIDTH-1:0];
        end
    end

    assign node_value = node_reg;

endmodule

`default_nettype wire

// File: hw/rtl/c2n_ctrl.sv
// controller: sequences write items and the corner reads of a query
// depends on c2n_pkg and the assertion macro header
`default_nettype none
`include "cell_to_node_recenter_top_macros.svh"

module c2n_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                s_action,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output c2n_pkg::dp_cmd_t         cmd,
    input  wire c2n_pkg::dp_status_t status
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]                state_reg, state_next;
    logic [c2n_pkg::SEL_W-1:0] k_reg, k_next;
    logic [c2n_pkg::SEL_W-1:0] last_reg, last_next;
    logic                      rd_pend_reg, rd_pend_next;
    logic                      m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        last_next    = last_reg;
        rd_pend_next = 1'b0;
        s_ready      = 1'b0;
        cmd          = '0;
        // read data arrives in the cycle after its address
        cmd.acc      = rd_pend_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_action == c2n_pkg::ACT_WRITE) begin
                        cmd.write = 1'b1;
                    end else begin
                        cmd.load   = 1'b1;
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                last_next  = status.reads_last;
                k_next     = '0;
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.rd_sel   = k_reg;
                rd_pend_next = 1'b1;
                if (k_reg == last_reg) begin
                    state_next = ST_DRAIN;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            last_reg    <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            last_reg    <= last_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `C2N_ASSERT(a_query_starts, aclk, aresetn,
        s_valid && s_ready && (s_action == c2n_pkg::ACT_QUERY) |=> state_reg == ST_PREP)
    `C2N_ASSERT(a_pend_after_read, aclk, aresetn,
        rd_pend_reg |-> $past(state_reg) == ST_READ)
    `C2N_ASSERT(a_corner_bound, aclk, aresetn,
        state_reg == ST_READ |-> k_reg <= last_reg)
    `C2N_ASSERT_ALWAYS(a_reset_idle, aclk,
        !aresetn |=> state_reg == ST_IDLE && !m_valid_reg)

endmodule

`default_nettype wire

// File: hw/rtl/cell_to_node_recenter_top.sv
// cell to node recenter: averages the cells straddling a grid node
// Usage: one input channel carries write items (store one cell sample at a cell
// index) and query items (return the floored mean of the 2, 4 or 8 cells around a
// node). Only queries produce a result item on the m_ channel. A separate config
// channel writes dims, strides and clamp bounds by register index; it is always
// ready and must only be used while the block is idle.
// Throughput: a write item is taken every cycle while the block is idle. A query reads
// its 2^dims cells one per cycle from the single-port field memory and holds the input
// off while it steps through prep, the corner reads, drain and done, so no new item is
// taken until the query is through; the next item is accepted the cycle after the
// result register is loaded.
// Stall: the result sits in an output register until m_ready; a finished query
// waits there while it is full, and further items are held off meanwhile.
// Reset: aresetn (synchronous, active low) restores the config defaults and idles
// the controller. The field memory is not cleared: cells must be written before a
// query reads them.
// depends on c2n_pkg, c2n_ctrl, c2n_dpath
`default_nettype none

module cell_to_node_recenter_top #(
    parameter int AXIS_CELLS   = 16,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [c2n_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [c2n_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_action,
    input  wire logic [c2n_pkg::COORD_W-1:0]     s_coord_x,
    input  wire logic [c2n_pkg::COORD_W-1:0]     s_coord_y,
    input  wire logic [c2n_pkg::COORD_W-1:0]     s_coord_z,
    input  wire logic signed [SAMPLE_WIDTH-1:0]  s_sample,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]       m_node_value
);

    c2n_pkg::dp_cmd_t    cmd;
    c2n_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    c2n_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .status   (status)
    );

    c2n_dpath #(
        .AXIS_CELLS   (AXIS_CELLS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_coord_x (s_coord_x),
        .in_coord_y (s_coord_y),
        .in_coord_z (s_coord_z),
        .in_sample  (s_sample),
        .cmd        (cmd),
        .status     (status),
        .node_value (m_node_value)
    );

endmodule

`default_nettype wire
